// File: rtl/mahfs_pkg.sv
// Package for the MPEG audio header frame-size block: widths, header codes and
// the bitrate and sample rate tables. It depends on nothing else.
package mahfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KbpsW  = 9;
  localparam int unsigned RateW  = 16;
  localparam int unsigned FactW  = 18;
  localparam int unsigned NumW   = 26;
  localparam int unsigned QuotW  = 12;
  localparam int unsigned LenW   = 12;
  localparam int unsigned CntW   = 4;

  localparam logic [ByteW-1:0] SyncByte    = 8'hFF;
  localparam logic [2:0]       SyncBits    = 3'b111;
  localparam logic [1:0]       VerMpeg1    = 2'b11;
  localparam logic [1:0]       VerReserved = 2'b01;
  localparam logic [1:0]       LayerRsvd   = 2'b00;
  localparam logic [3:0]       BidxBad     = 4'hF;
  localparam logic [1:0]       SidxBad     = 2'b11;
  localparam logic [1:0]       SlotLayer1  = 2'd0;

  localparam logic [FactW-1:0] FactLayer1  = 18'd12000;
  localparam logic [FactW-1:0] FactLayer23 = 18'd144000;

  // Bitrate in kbit/s by version group, layer slot (0 is Layer I) and index.
  localparam logic [KbpsW-1:0] KbpsTable [2][4][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{default: 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{default: 9'd0}
    }
  };

  // Sample rate in Hz by version code and sample rate index.
  localparam logic [RateW-1:0] RateTable [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

endpackage

// File: rtl/mahfs_div.sv
// Bit-serial restoring divider that produces one quotient bit per cycle.
// It depends on mahfs_pkg for its widths.
module mahfs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mahfs_pkg::NumW-1:0]  num_i,
  input  logic [mahfs_pkg::RateW-1:0] den_i,
  output logic                        done_o,
  output logic [mahfs_pkg::QuotW-1:0] quot_o
);

  localparam int unsigned DivW = mahfs_pkg::RateW + mahfs_pkg::QuotW - 1;
  localparam int unsigned CmpW = (DivW > mahfs_pkg::NumW) ? DivW : mahfs_pkg::NumW;

  logic [mahfs_pkg::NumW-1:0]  rem_q;
  logic [DivW-1:0]             div_q;
  logic [mahfs_pkg::QuotW-1:0] quot_q;
  logic [mahfs_pkg::CntW-1:0]  cnt_q;
  logic                        busy_q;
  logic                        done_q;
  logic [CmpW:0]               diff;
  logic                        fits;

  assign diff   = (CmpW+1)'(rem_q) - (CmpW+1)'(div_q);
  assign fits   = ~diff[CmpW];
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mahfs_pkg::CntW'(mahfs_pkg::QuotW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mahfs_pkg::CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      div_q  <= {den_i, (mahfs_pkg::QuotW-1)'(0)};
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff[mahfs_pkg::NumW-1:0];
      end
      div_q  <= div_q >> 1;
      quot_q <= {quot_q[mahfs_pkg::QuotW-2:0], fits};
    end
  end

endmodule

// File: rtl/mpeg_audio_header_frame_size.sv
// MPEG audio header check and frame length. An invalid header, or a valid one whose
// rate bits match the stored ones, gives its result in the cycle after the transfer; a
// changed header runs StLoad, StDiv (12-step bit-serial divider in mahfs_div) and StFin,
// which waits for a free output. One header at a time. Depends on mahfs_pkg and mahfs_div.
module mpeg_audio_header_frame_size (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mahfs_pkg::ByteW-1:0]  hdr_byte0_i,
  input  logic [mahfs_pkg::ByteW-1:0]  hdr_byte1_i,
  input  logic [mahfs_pkg::ByteW-1:0]  hdr_byte2_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         header_valid_o,
  output logic                         header_changed_o,
  output logic [mahfs_pkg::LenW-1:0]   frame_bytes_o
);

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StDiv,
    StFin
  } state_e;

  state_e                         state_q;
  logic [mahfs_pkg::ByteW-1:0]    last_q;
  logic [mahfs_pkg::LenW-1:0]     len_q;
  logic [mahfs_pkg::KbpsW-1:0]    kbps_q;
  logic [mahfs_pkg::FactW-1:0]    fact_q;
  logic [mahfs_pkg::RateW-1:0]    rate_q;
  logic                           layer1_q;
  logic                           pad_q;
  logic [mahfs_pkg::ByteW-1:0]    b2_q;
  logic                           out_valid_q;
  logic                           hv_q;
  logic                           hc_q;
  logic [mahfs_pkg::LenW-1:0]     fb_q;

  logic [1:0]                     ver;
  logic [1:0]                     lcode;
  logic [1:0]                     slot;
  logic                           group;
  logic                           hdr_ok;
  logic                           changed;
  logic                           out_free;
  logic                           in_xfer;
  logic [mahfs_pkg::NumW-1:0]     num;
  logic                           div_done;
  logic [mahfs_pkg::QuotW-1:0]    quot;
  logic [mahfs_pkg::LenW-1:0]     new_len;

  assign ver   = hdr_byte1_i[4:3];
  assign lcode = hdr_byte1_i[2:1];
  assign slot  = 2'd3 - lcode;
  assign group = (ver != mahfs_pkg::VerMpeg1);

  assign hdr_ok = (hdr_byte0_i == mahfs_pkg::SyncByte)
               && (hdr_byte1_i[7:5] == mahfs_pkg::SyncBits)
               && (ver != mahfs_pkg::VerReserved)
               && (lcode != mahfs_pkg::LayerRsvd)
               && (hdr_byte2_i[7:4] != mahfs_pkg::BidxBad)
               && (hdr_byte2_i[3:2] != mahfs_pkg::SidxBad);
  assign changed = hdr_ok && (hdr_byte2_i[7:2] != last_q[7:2]);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign num = mahfs_pkg::NumW'(kbps_q) * mahfs_pkg::NumW'(fact_q);

  assign new_len = layer1_q ? mahfs_pkg::LenW'((quot + mahfs_pkg::QuotW'(pad_q)) << 2)
                            : mahfs_pkg::LenW'(quot + mahfs_pkg::QuotW'(pad_q));

  mahfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == StLoad),
    .num_i  (num),
    .den_i  (rate_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign out_valid_o      = out_valid_q;
  assign header_valid_o   = hv_q;
  assign header_changed_o = hc_q;
  assign frame_bytes_o    = fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= mahfs_pkg::SyncByte;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      hv_q        <= 1'b0;
      hc_q        <= 1'b0;
      fb_q        <= '0;
      kbps_q      <= '0;
      fact_q      <= '0;
      rate_q      <= '0;
      layer1_q    <= 1'b0;
      pad_q       <= 1'b0;
      b2_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            if (changed) begin
              kbps_q   <= mahfs_pkg::KbpsTable[group][slot][hdr_byte2_i[7:4]];
              fact_q   <= (slot == mahfs_pkg::SlotLayer1) ? mahfs_pkg::FactLayer1
                                                          : mahfs_pkg::FactLayer23;
              rate_q   <= mahfs_pkg::RateTable[ver][hdr_byte2_i[3:2]];
              layer1_q <= (slot == mahfs_pkg::SlotLayer1);
              pad_q    <= hdr_byte2_i[1];
              b2_q     <= hdr_byte2_i;
              state_q  <= StLoad;
            end else begin
              out_valid_q <= 1'b1;
              hv_q        <= hdr_ok;
              hc_q        <= 1'b0;
              fb_q        <= len_q;
            end
          end
        end
        StLoad: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            len_q       <= new_len;
            last_q      <= b2_q;
            out_valid_q <= 1'b1;
            hv_q        <= 1'b1;
            hc_q        <= 1'b1;
            fb_q        <= new_len;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: rtl/mahfs_chk.sv
// Port-level checker for mpeg_audio_header_frame_size, bound to the top level.
// It depends only on mahfs_pkg for the port widths.
module mahfs_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [mahfs_pkg::ByteW-1:0] hdr_byte0_i,
  input logic [mahfs_pkg::ByteW-1:0] hdr_byte1_i,
  input logic [mahfs_pkg::ByteW-1:0] hdr_byte2_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        header_valid_o,
  input logic                        header_changed_o,
  input logic [mahfs_pkg::LenW-1:0]  frame_bytes_o
);

  a_changed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_changed_o |-> header_valid_o)
    else $error("changed header reported as invalid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_bytes_o)
      && $stable(header_valid_o) && $stable(header_changed_o))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(hdr_byte0_i)
      && $stable(hdr_byte1_i) && $stable(hdr_byte2_i))
    else $error("waiting header changed before its transfer");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result is stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("header transfer neither answered nor in progress");

endmodule

bind mpeg_audio_header_frame_size mahfs_chk u_mahfs_chk (.*);

// File: sim/tb_mpeg_audio_header_frame_size.sv
// Testbench for mpeg_audio_header_frame_size: header checks, rate change detection
// and frame length, predicted per transfer and compared on each output transfer.
// Depends on mahfs_pkg and the block's RTL.
module tb_mpeg_audio_header_frame_size;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 20;

  localparam int unsigned BitrateKbps [2][3][16] = '{
    '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
    },
    '{
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    }
  };

  localparam int unsigned SampleHz [4][4] = '{
    '{11025, 12000, 8000, 0},
    '{0, 0, 0, 0},
    '{22050, 24000, 16000, 0},
    '{44100, 48000, 32000, 0}
  };

  typedef struct packed {
    logic                       hdr_ok;
    logic                       rate_changed;
    logic [mahfs_pkg::LenW-1:0] length;
  } frame_info_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [mahfs_pkg::ByteW-1:0] hdr_byte0 = '0;
  logic [mahfs_pkg::ByteW-1:0] hdr_byte1 = '0;
  logic [mahfs_pkg::ByteW-1:0] hdr_byte2 = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        header_valid;
  logic                        header_changed;
  logic [mahfs_pkg::LenW-1:0]  frame_bytes;

  logic [mahfs_pkg::ByteW-1:0] last_rate = 8'hFF;
  logic [mahfs_pkg::LenW-1:0]  stored_len = '0;
  frame_info_t                 expected_frames[$];
  int unsigned                 n_sent = 0;
  int unsigned                 n_checked = 0;
  int unsigned                 n_errors = 0;
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_stall_pct = 0;
  bit                          hold_req = 1'b0;
  int unsigned                 hold_left = 0;

  mpeg_audio_header_frame_size dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .hdr_byte0_i     (hdr_byte0),
    .hdr_byte1_i     (hdr_byte1),
    .hdr_byte2_i     (hdr_byte2),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .header_valid_o  (header_valid),
    .header_changed_o(header_changed),
    .frame_bytes_o   (frame_bytes)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic header_is_valid(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    return b0 == mahfs_pkg::SyncByte && b1[7:5] == mahfs_pkg::SyncBits &&
           b1[4:3] != mahfs_pkg::VerReserved && b1[2:1] != mahfs_pkg::LayerRsvd &&
           b2[7:4] != mahfs_pkg::BidxBad && b2[3:2] != mahfs_pkg::SidxBad;
  endfunction

  function automatic logic [mahfs_pkg::LenW-1:0] frame_length(logic [7:0] b1,
                                                              logic [7:0] b2);
    logic [1:0]  ver;
    logic [1:0]  slot;
    int unsigned bits;
    int unsigned hz;
    ver  = b1[4:3];
    slot = 2'd3 - b1[2:1];
    bits = BitrateKbps[(ver == mahfs_pkg::VerMpeg1) ? 0 : 1][slot][b2[7:4]] * 1000;
    hz   = SampleHz[ver][b2[3:2]];
    if (hz == 0) begin
      return '0;
    end
    if (slot == mahfs_pkg::SlotLayer1) begin
      return mahfs_pkg::LenW'(((12 * bits) / hz + b2[1]) * 4);
    end
    return mahfs_pkg::LenW'((144 * bits) / hz + b2[1]);
  endfunction

  function automatic frame_info_t predict_frame(logic [7:0] b0, logic [7:0] b1,
                                                logic [7:0] b2);
    frame_info_t r;
    r.hdr_ok       = header_is_valid(b0, b1, b2);
    r.rate_changed = r.hdr_ok && (b2[7:2] != last_rate[7:2]);
    if (r.rate_changed) begin
      stored_len = frame_length(b1, b2);
      last_rate  = b2;
    end
    r.length = stored_len;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    hdr_byte0 <= b0;
    hdr_byte1 <= b1;
    hdr_byte2 <= b2;
    do begin
      @(posedge clk_i);
    end while (!in_ready);
    expected_frames.push_back(predict_frame(b0, b1, b2));
    n_sent++;
  endtask

  task automatic random_header(output logic [7:0] b0, output logic [7:0] b1,
                               output logic [7:0] b2);
    int unsigned pick;
    logic [1:0]  ver;
    pick = $urandom_range(0, 99);
    ver  = 2'($urandom_range(0, 2));
    if (ver == mahfs_pkg::VerReserved) begin
      ver = mahfs_pkg::VerMpeg1;
    end
    b0 = mahfs_pkg::SyncByte;
    b1 = {mahfs_pkg::SyncBits, ver, 2'($urandom_range(1, 3)), 1'($urandom_range(0, 1))};
    if ($urandom_range(0, 2) == 0) begin
      b2[7:2] = last_rate[7:2];
    end else begin
      b2[7:2] = {4'($urandom_range(0, 14)), 2'($urandom_range(0, 2))};
    end
    b2[1:0] = 2'($urandom_range(0, 3));
    if (pick >= 85) begin
      b0 = 8'($urandom);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
    end else if (pick >= 70) begin
      case ($urandom_range(0, 5))
        0: b0 = 8'($urandom_range(0, 254));
        1: b1[7:5] = 3'($urandom_range(0, 6));
        2: b1[4:3] = mahfs_pkg::VerReserved;
        3: b1[2:1] = mahfs_pkg::LayerRsvd;
        4: b2[7:4] = mahfs_pkg::BidxBad;
        default: b2[3:2] = mahfs_pkg::SidxBad;
      endcase
    end
  endtask

  task automatic send_random(input int unsigned count);
    logic [7:0] b0, b1, b2;
    repeat (count) begin
      random_header(b0, b1, b2);
      send_header(b0, b1, b2);
    end
  endtask

  task automatic test_invalid_headers();
    send_header(8'h00, 8'h00, 8'h00);
    send_header(8'hFF, 8'hFF, 8'hFF);
    send_header(8'h00, 8'hFB, 8'h90);
    send_header(8'hFE, 8'hFB, 8'h90);
    send_header(8'hFF, 8'h1B, 8'h90);
    send_header(8'hFF, 8'hEB, 8'h90);
    send_header(8'hFF, 8'hF9, 8'h90);
    send_header(8'hFF, 8'hFB, 8'hF0);
    send_header(8'hFF, 8'hFB, 8'h9C);
  endtask

  task automatic test_field_extremes();
    send_header(8'hFF, 8'hFB, 8'h90);
    send_header(8'hFF, 8'hFF, 8'h12);
    send_header(8'hFF, 8'hE4, 8'hEA);
    send_header(8'hFF, 8'hF3, 8'hE4);
    send_header(8'hFF, 8'hE7, 8'hE8);
    send_header(8'hFF, 8'hFB, 8'h01);
    send_header(8'hFF, 8'hFB, 8'hFF);
  endtask

  task automatic test_free_format();
    send_header(8'hFF, 8'hFD, 8'h00);
    send_header(8'hFF, 8'hFD, 8'h06);
    send_header(8'hFF, 8'hFF, 8'h0A);
  endtask

  task automatic test_same_rate_bits();
    send_header(8'hFF, 8'hFB, 8'h90);
    send_header(8'hFF, 8'hFB, 8'h92);
    send_header(8'hFF, 8'hFD, 8'h93);
    send_header(8'hFF, 8'hE5, 8'h91);
  endtask

  task automatic test_random(input int unsigned count, input int unsigned idle,
                             input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    send_random(count);
  endtask

  // The output side stops for a long stretch while headers keep coming.
  task automatic test_receiver_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_random(12);
  endtask

  // The input side goes quiet until every pending result has been seen.
  task automatic test_sender_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 13;
    send_random(5);
    in_valid <= 1'b0;
    wait (n_checked == n_sent);
    @(posedge clk_i);
    send_random(5);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    frame_info_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                 header_valid, header_changed, frame_bytes);
        n_errors++;
      end else begin
        want = expected_frames.pop_front();
        n_checked++;
        compare_field("header_valid", want.hdr_ok, header_valid);
        compare_field("header_changed", want.rate_changed, header_changed);
        compare_field("frame_bytes", want.length, frame_bytes);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_invalid_headers();
    test_field_extremes();
    test_free_format();
    test_same_rate_bits();
    test_random(140, 0, 0);
    test_random(140, 81, 0);
    test_random(140, 0, 81);
    test_random(140, 13, 13);
    test_receiver_hold();
    test_sender_pause();
    in_valid <= 1'b0;
    wait (n_checked == n_sent);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
